### hdl/merge_sort_engine_defines.svh
// Assertion helpers used by the merge sort engine datapath.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define MSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("merge sort engine check failed");

// Consequent in the cycle after the antecedent.
`define MSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("merge sort engine check failed");

`endif

### hdl/mse_pkg.sv
package mse_pkg;

    localparam int DataW = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_SEG,
        ST_RD,
        ST_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic pass_init;
        logic pass_next;
        logic seg_init;
        logic rd;
        logic wr;
        logic out_init;
        logic out_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic width_done;
        logic lo_done;
        logic seg_last;
        logic out_taken;
        logic out_done;
    } status_t;

endpackage

### hdl/merge_sort_engine.sv
// Loading takes one word per cycle while in_ready is high (load state only); the word flagged
// last starts the sort. Sorting n words takes ceil(log2 n) merge passes, each a
// read/compare-write loop on the buffers; results leave one at a time from the buffer read port
// and output register, and the next is read only after the previous one is taken.
// Reset (rst_n low, asynchronous) empties the list and the output; buffers are not cleared.
module merge_sort_engine #(
    parameter int MAX_LEN = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] sorted_value,
    output logic               final_res,
    output logic               truncated
);
    import mse_pkg::*;

    cmd_t    cmd;
    status_t st;

    mse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .last     (last),
        .st       (st),
        .cmd      (cmd)
    );

    mse_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .truncated    (truncated)
    );

endmodule

### hdl/mse_datapath.sv
`include "merge_sort_engine_defines.svh"

module mse_datapath #(
    parameter int MAX_LEN = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mse_pkg::cmd_t         cmd,
    output mse_pkg::status_t      st,
    input  logic signed [31:0]    value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    sorted_value,
    output logic                  final_res,
    output logic                  truncated
);
    import mse_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MaxN = CW'(MAX_LEN);

    // Two ping-pong buffers: each merge pass reads one and writes the other.
    logic signed [DataW-1:0] mem_a [MAX_LEN];
    logic signed [DataW-1:0] mem_b [MAX_LEN];

    logic signed [DataW-1:0] a_q0_reg, a_q1_reg, b_q0_reg, b_q1_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          src_sel_reg, src_sel_next;
    logic [WW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [DataW-1:0] sorted_reg;
    logic                    final_reg;
    logic                    trunc_reg;

    logic [SW-1:0]           sum_mid, sum_hi;
    logic [CW-1:0]           mid_c, hi_c;
    logic signed [DataW-1:0] q_i, q_j, merge_word;
    logic                    take_left;
    logic                    load_wr;
    logic                    out_fire;

    assign q_i = src_sel_reg ? b_q0_reg : a_q0_reg;
    assign q_j = src_sel_reg ? b_q1_reg : a_q1_reg;

    // Left run wins ties so the merge stays stable.
    assign take_left  = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (q_i <= q_j));
    assign merge_word = take_left ? q_i : q_j;

    assign sum_mid = SW'(lo_reg) + SW'(width_reg);
    assign sum_hi  = sum_mid + SW'(width_reg);
    assign mid_c   = (sum_mid >= SW'(count_reg)) ? count_reg : sum_mid[CW-1:0];
    assign hi_c    = (sum_hi >= SW'(count_reg)) ? count_reg : sum_hi[CW-1:0];

    assign load_wr  = cmd.load && (count_reg < MaxN);
    assign out_fire = out_valid_reg && out_ready;

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        src_sel_next   = src_sel_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            if (load_wr)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.sort_init)
        begin
            width_next   = WW'(1);
            src_sel_next = 1'b0;
        end
        if (cmd.pass_init)
        begin
            lo_next = '0;
        end
        if (cmd.pass_next)
        begin
            width_next   = width_reg << 1;
            src_sel_next = ~src_sel_reg;
        end
        if (cmd.seg_init)
        begin
            mid_next = mid_c;
            hi_next  = hi_c;
            i_next   = lo_reg;
            j_next   = mid_c;
            k_next   = lo_reg;
            // The next segment starts where this one ends; a clipped end means the pass is over.
            lo_next  = hi_c;
        end
        if (cmd.wr)
        begin
            k_next = k_reg + CW'(1);
            if (take_left)
            begin
                i_next = i_reg + CW'(1);
            end
            else
            begin
                j_next = j_reg + CW'(1);
            end
        end
        if (cmd.out_init)
        begin
            i_next = '0;
        end
        if (cmd.out_load)
        begin
            i_next         = i_reg + CW'(1);
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            src_sel_reg   <= 1'b0;
            width_reg     <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            src_sel_reg   <= src_sel_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            mem_a[count_reg[AW-1:0]] <= value;
        end
        else if (cmd.wr && src_sel_reg)
        begin
            mem_a[k_reg[AW-1:0]] <= merge_word;
        end
        if (cmd.rd)
        begin
            a_q0_reg <= mem_a[i_reg[AW-1:0]];
            a_q1_reg <= mem_a[j_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr && !src_sel_reg)
        begin
            mem_b[k_reg[AW-1:0]] <= merge_word;
        end
        if (cmd.rd)
        begin
            b_q0_reg <= mem_b[i_reg[AW-1:0]];
            b_q1_reg <= mem_b[j_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sorted_reg <= q_i;
            final_reg  <= ((i_reg + CW'(1)) == count_reg);
            trunc_reg  <= ovf_reg;
        end
    end

    assign st.width_done = (width_reg >= WW'(count_reg));
    assign st.lo_done    = (lo_reg >= count_reg);
    assign st.seg_last   = ((k_reg + CW'(1)) >= hi_reg);
    assign st.out_taken  = out_fire;
    assign st.out_done   = (i_reg == count_reg);

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_reg;
    assign final_res    = final_reg;
    assign truncated    = trunc_reg;

    `MSE_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= MaxN)
    `MSE_ASSERT_IMP(a_k_in_seg, cmd.wr, k_reg < hi_reg)
    `MSE_ASSERT_IMP(a_run_nonempty, cmd.wr, (i_reg < mid_reg) || (j_reg < hi_reg))
    `MSE_ASSERT_IMP(a_out_free, cmd.out_load, !out_valid_reg)
    `MSE_ASSERT_NEXT(a_clear_after_final, out_fire && final_reg, count_reg == '0)

endmodule

### hdl/mse_ctrl.sv
module mse_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             last,
    input  mse_pkg::status_t st,
    output mse_pkg::cmd_t    cmd
);
    import mse_pkg::*;

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                if (st.width_done)
                begin
                    cmd.out_init = 1'b1;
                    state_next   = ST_OUT_RD;
                end
                else
                begin
                    cmd.pass_init = 1'b1;
                    state_next    = ST_SEG;
                end
            end
            ST_SEG:
            begin
                if (st.lo_done)
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = ST_PASS;
                end
                else
                begin
                    cmd.seg_init = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = st.seg_last ? ST_SEG : ST_RD;
            end
            ST_OUT_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (st.out_taken)
                begin
                    if (st.out_done)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule
